FILE: hw/rtl/bmp4_pkg.sv
package bmp4_pkg;

    // Fixed limits of the decoder
    localparam logic [31:0] MAX_WIDTH       = 32'd1024;
    localparam logic [31:0] MAX_HEIGHT      = 32'd1024;
    localparam logic [31:0] PALETTE_ENTRIES = 32'd16;
    localparam int          MAX_RESULTS     = 3;

    // File format constants
    localparam logic [15:0] BMP_MAGIC   = 16'h4D42;
    localparam logic [31:0] INFO_SIZE   = 32'd40;
    localparam logic [15:0] BIT_DEPTH   = 16'd4;
    localparam logic [31:0] HDR_BYTES   = 32'd54;

    // Byte positions that close a header field
    localparam logic [31:0] BP_MAGIC    = 32'd1;
    localparam logic [31:0] BP_OFFSET   = 32'd13;
    localparam logic [31:0] BP_HDR_SIZE = 32'd17;
    localparam logic [31:0] BP_WIDTH    = 32'd21;
    localparam logic [31:0] BP_HEIGHT   = 32'd25;
    localparam logic [31:0] BP_DEPTH    = 32'd29;
    localparam logic [31:0] BP_COMPRESS = 32'd33;
    localparam logic [31:0] BP_COLORS   = 32'd49;
    localparam logic [31:0] BP_LAST     = 32'd53;

    // Error codes
    localparam logic [2:0] ERR_MAGIC     = 3'd0;
    localparam logic [2:0] ERR_HDR_SIZE  = 3'd1;
    localparam logic [2:0] ERR_DEPTH     = 3'd2;
    localparam logic [2:0] ERR_COMPRESS  = 3'd3;
    localparam logic [2:0] ERR_TOPDOWN   = 3'd4;
    localparam logic [2:0] ERR_LARGE     = 3'd5;
    localparam logic [2:0] ERR_OFFSET    = 3'd6;
    localparam logic [2:0] ERR_TRUNCATED = 3'd7;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_SKIP,
        PH_PIXELS,
        PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PALETTE,
        KIND_PIXEL,
        KIND_ERROR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  err_code;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [3:0]  pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        image_done;
    } result_t;

    // All results caused by one input byte
    typedef struct packed {
        logic [1:0]                  cnt;
        result_t [MAX_RESULTS-1:0]   res;
    } bundle_t;

    function automatic result_t res_header(input logic [10:0] w, input logic [10:0] h);
        result_t r;
        r = '0;
        r.kind  = KIND_HEADER;
        r.pos_x = w;
        r.pos_y = h;
        return r;
    endfunction

    function automatic result_t res_palette(input logic [3:0] idx, input logic [7:0] rd,
                                            input logic [7:0] gr, input logic [7:0] bl,
                                            input logic [7:0] al);
        result_t r;
        r = '0;
        r.kind  = KIND_PALETTE;
        r.pos_x = {7'd0, idx};
        r.red   = rd;
        r.green = gr;
        r.blue  = bl;
        r.alpha = al;
        return r;
    endfunction

    function automatic result_t res_pixel(input logic [10:0] x, input logic [10:0] y,
                                          input logic [3:0] v, input logic done);
        result_t r;
        r = '0;
        r.kind        = KIND_PIXEL;
        r.pos_x       = x;
        r.pos_y       = y;
        r.pixel_index = v;
        r.image_done  = done;
        return r;
    endfunction

    function automatic result_t res_error(input logic [2:0] code);
        result_t r;
        r = '0;
        r.kind     = KIND_ERROR;
        r.err_code = code;
        return r;
    endfunction

endpackage

FILE: hw/rtl/bmp4_parser.sv
module bmp4_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,     // data_byte
    input  logic              s_tlast,     // stream_end
    input  logic              q_full,
    output logic              q_push,
    output bmp4_pkg::bundle_t q_bundle
);
    import bmp4_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] byte_pos_reg, byte_pos_next;
    logic [31:0] fa_reg, fa_next;
    logic [31:0] data_offset_reg, data_offset_next;
    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic [4:0]  pal_count_reg, pal_count_next;
    logic [10:0] col_reg, col_next;
    logic [10:0] row_reg, row_next;
    logic [1:0]  pad_reg, pad_next;
    logic        topdown_reg, topdown_next;
    logic        large_reg, large_next;

    logic        accept;
    logic [31:0] fa_shift;
    bundle_t     bnd;
    logic [1:0]  n;
    logic        hdr_err;
    logic [2:0]  hdr_code;
    logic [6:0]  pal_k;
    logic [3:0]  pal_idx;
    logic        skip_hit;
    logic        do_pixel;
    logic [10:0] pc, pr, py, pr_inc;
    logic [1:0]  pp;
    logic [11:0] c1, c2, w12, w_inc;
    logic        second;
    logic        last_row;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_bundle = bnd;
    assign q_push   = accept && (bnd.cnt != 2'd0);

    // Per-byte parse: next state and the results this byte causes
    always_comb
    begin
        phase_next       = phase_reg;
        byte_pos_next    = byte_pos_reg;
        fa_next          = fa_reg;
        data_offset_next = data_offset_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        pal_count_next   = pal_count_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        pad_next         = pad_reg;
        topdown_next     = topdown_reg;
        large_next       = large_reg;

        bnd      = '0;
        n        = 2'd0;
        hdr_err  = 1'b0;
        hdr_code = ERR_MAGIC;
        fa_shift = {s_tdata, fa_reg[31:8]};
        pal_k    = byte_pos_reg[6:0] - HDR_BYTES[6:0];
        pal_idx  = pal_k[5:2];
        skip_hit = (byte_pos_reg == data_offset_reg);
        do_pixel = (phase_reg == PH_PIXELS) || ((phase_reg == PH_SKIP) && skip_hit);

        // pixel counters start from zero on the first pixel byte
        pc = (phase_reg == PH_SKIP) ? 11'd0 : col_reg;
        pr = (phase_reg == PH_SKIP) ? 11'd0 : row_reg;
        pp = (phase_reg == PH_SKIP) ? 2'd0 : pad_reg;
        py       = height_reg - 11'd1 - pr;
        pr_inc   = pr + 11'd1;
        c1       = {1'b0, pc} + 12'd1;
        c2       = {1'b0, pc} + 12'd2;
        w12      = {1'b0, width_reg};
        w_inc    = w12 + 12'd1;
        second   = (c1 < w12);
        last_row = (pr_inc == height_reg);

        unique case (phase_reg)
            PH_HEADER:
            begin
                fa_next = fa_shift;
                unique case (byte_pos_reg)
                    BP_MAGIC:
                    begin
                        if (fa_shift[31:16] != BMP_MAGIC)
                        begin
                            hdr_err  = 1'b1;
                            hdr_code = ERR_MAGIC;
                        end
                    end
                    BP_OFFSET: data_offset_next = fa_shift;
                    BP_HDR_SIZE:
                    begin
                        if (fa_shift != INFO_SIZE)
                        begin
                            hdr_err  = 1'b1;
                            hdr_code = ERR_HDR_SIZE;
                        end
                    end
                    BP_WIDTH:
                    begin
                        if (fa_shift[31] || fa_shift > MAX_WIDTH)
                            large_next = 1'b1;
                        else
                            width_next = fa_shift[10:0];
                    end
                    BP_HEIGHT:
                    begin
                        if (fa_shift[31])
                            topdown_next = 1'b1;
                        else if (fa_shift > MAX_HEIGHT)
                            large_next = 1'b1;
                        else
                            height_next = fa_shift[10:0];
                    end
                    BP_DEPTH:
                    begin
                        if (fa_shift[31:16] != BIT_DEPTH)
                        begin
                            hdr_err  = 1'b1;
                            hdr_code = ERR_DEPTH;
                        end
                    end
                    BP_COMPRESS:
                    begin
                        if (fa_shift != 32'd0)
                        begin
                            hdr_err  = 1'b1;
                            hdr_code = ERR_COMPRESS;
                        end
                    end
                    BP_COLORS:
                    begin
                        // zero colors used means a full palette
                        if (fa_shift == 32'd0)
                            pal_count_next = PALETTE_ENTRIES[4:0];
                        else if (fa_shift > PALETTE_ENTRIES)
                            large_next = 1'b1;
                        else
                            pal_count_next = fa_shift[4:0];
                    end
                    BP_LAST:
                    begin
                        priority if (topdown_reg)
                        begin
                            hdr_err  = 1'b1;
                            hdr_code = ERR_TOPDOWN;
                        end
                        else if (large_reg)
                        begin
                            hdr_err  = 1'b1;
                            hdr_code = ERR_LARGE;
                        end
                        else if (data_offset_reg < HDR_BYTES + {25'd0, pal_count_reg, 2'b00})
                        begin
                            hdr_err  = 1'b1;
                            hdr_code = ERR_OFFSET;
                        end
                        else
                        begin
                            bnd.res[n] = res_header(width_reg, height_reg);
                            n          = n + 2'd1;
                            phase_next = PH_PALETTE;
                        end
                    end
                    default: ;
                endcase
                if (hdr_err)
                begin
                    bnd.res[n] = res_error(hdr_code);
                    n          = n + 2'd1;
                    phase_next = PH_DRAIN;
                end
                byte_pos_next = byte_pos_reg + 32'd1;
            end

            PH_PALETTE:
            begin
                fa_next = fa_shift;
                if (pal_k[1:0] == 2'd3)
                begin
                    bnd.res[n] = res_palette(pal_idx, fa_shift[23:16], fa_shift[15:8],
                                             fa_shift[7:0], s_tdata);
                    n          = n + 2'd1;
                    if ({1'b0, pal_idx} + 5'd1 >= pal_count_reg)
                    begin
                        if (width_reg == 11'd0 || height_reg == 11'd0)
                            phase_next = PH_DRAIN;
                        else
                            phase_next = PH_SKIP;
                    end
                end
                byte_pos_next = byte_pos_reg + 32'd1;
            end

            PH_SKIP:
            begin
                if (skip_hit)
                    phase_next = PH_PIXELS;
                else
                    byte_pos_next = byte_pos_reg + 32'd1;
            end

            PH_PIXELS: ;
            PH_DRAIN: ;
            default: ;
        endcase

        // Pixel byte: row padding or up to two pixels, high nibble first
        if (do_pixel)
        begin
            col_next = pc;
            row_next = pr;
            pad_next = pp;
            if (pp != 2'd0)
            begin
                pad_next = pp - 2'd1;
            end
            else
            begin
                bnd.res[n] = res_pixel(pc, py, s_tdata[7:4], (c1 == w12) && last_row);
                n          = n + 2'd1;
                if (second)
                begin
                    bnd.res[n] = res_pixel(c1[10:0], py, s_tdata[3:0], (c2 == w12) && last_row);
                    n          = n + 2'd1;
                end
                if (!second || c2 >= w12)
                begin
                    row_next = pr_inc;
                    col_next = 11'd0;
                    if (pr_inc >= height_reg)
                        phase_next = PH_DRAIN;
                    else
                        pad_next = 2'd0 - w_inc[2:1];
                end
                else
                begin
                    col_next = c2[10:0];
                end
            end
        end

        // End of file: flag truncation, then expect a new header
        if (s_tlast)
        begin
            if (phase_next != PH_DRAIN)
            begin
                bnd.res[n] = res_error(ERR_TRUNCATED);
                n          = n + 2'd1;
            end
            phase_next    = PH_HEADER;
            byte_pos_next = 32'd0;
            fa_next       = 32'd0;
            topdown_next  = 1'b0;
            large_next    = 1'b0;
        end

        bnd.cnt = n;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            byte_pos_reg    <= '0;
            fa_reg          <= '0;
            data_offset_reg <= '0;
            width_reg       <= '0;
            height_reg      <= '0;
            pal_count_reg   <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            pad_reg         <= '0;
            topdown_reg     <= 1'b0;
            large_reg       <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            fa_reg          <= fa_next;
            data_offset_reg <= data_offset_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            pal_count_reg   <= pal_count_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            pad_reg         <= pad_next;
            topdown_reg     <= topdown_next;
            large_reg       <= large_next;
        end
    end

endmodule

FILE: hw/rtl/bmp4_queue.sv
module bmp4_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bmp4_pkg::bundle_t wr_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output bmp4_pkg::bundle_t rd_data
);
    import bmp4_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Bundle storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hw/rtl/bmp4_emitter.sv
module bmp4_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  bmp4_pkg::bundle_t q_head,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    // err_code[2:0], pos_x[13:3], pos_y[24:14], pixel_index[28:25], red[36:29],
    // green[44:37], blue[52:45], alpha[60:53], image_done[61], zero[63:62]
    output logic [63:0]       m_tdata,
    output logic [1:0]        m_tuser,     // out_kind
    output logic              m_tlast      // last
);
    import bmp4_pkg::*;

    logic [1:0]  sub_reg, sub_next;
    logic        valid_reg, valid_next;
    result_t     res_reg;
    logic        last_reg;
    logic        load;
    logic        is_last;
    result_t     cur;

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, res_reg.image_done, res_reg.alpha, res_reg.blue,
                       res_reg.green, res_reg.red, res_reg.pixel_index,
                       res_reg.pos_y, res_reg.pos_x, res_reg.err_code};

    // Walk the head bundle one result per cycle into the output register, while m_tready does not hold it
    always_comb
    begin
        load    = (!valid_reg || m_tready) && !q_empty;
        cur     = q_head.res[sub_reg];
        is_last = (sub_reg == q_head.cnt - 2'd1);
        q_pop   = load && is_last;
        sub_next   = sub_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            sub_next   = is_last ? 2'd0 : sub_reg + 2'd1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg   <= sub_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= cur;
            last_reg <= is_last;
        end
    end

endmodule

FILE: hw/rtl/bmp4_stream_decoder.sv
// Streaming decoder for uncompressed 4-bit BMP files. Bytes of the file enter on the
// slave stream, one item per byte, with tlast on the final byte of the file. The block
// checks the file and info headers, reports the image size, each palette entry and each
// pixel (column and row counted from the top, bottom row first as stored), and reports
// errors with a code; after an error or a finished image bytes are dropped until tlast.
// A front parser takes one byte per cycle while the queue is not full and writes the
// up to three results of that byte as one bundle into a queue of QUEUE_DEPTH bundles;
// the back end sends one result per cycle while m_tready is high. Header, skip and
// palette bytes flow at one byte per cycle; pixel bytes, two results each at most, are
// held back by the single-result output register that follows the queue.
module bmp4_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // data_byte[7:0]
    input  logic        s_tlast,     // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // err_code[2:0], pos_x[13:3], pos_y[24:14], pixel_index[28:25], red[36:29],
    // green[44:37], blue[52:45], alpha[60:53], image_done[61], zero[63:62]
    output logic [63:0] m_tdata,
    output logic [1:0]  m_tuser,     // out_kind
    output logic        m_tlast      // last
);
    import bmp4_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_empty;
    bundle_t q_wr;
    bundle_t q_head;

    // Front: header, palette and pixel parsing
    bmp4_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_bundle (q_wr)
    );

    // Result bundles between front and back
    bmp4_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_data (q_head)
    );

    // Back: one result per cycle to the master stream while m_tready is high
    bmp4_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
